// ----- rtl/core/pesp_pkg.sv -----
// ----------------------------------------------------------------------------
// pesp_pkg
// shared constants, command table and types of the escape sequence parser
// ----------------------------------------------------------------------------
package pesp_pkg;

    localparam int VALUE_BITS_DEF = 24;
    localparam int OUT_VAL_W      = 24;
    localparam int CODE_W         = 6;
    localparam int TABLE_SIZE     = 45;

    // result kinds
    localparam logic [1:0] KIND_CMD     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // command codes
    localparam logic [CODE_W-1:0] CODE_PJL    = 6'd0;
    localparam logic [CODE_W-1:0] TABLE_BASE  = 6'd6;
    localparam logic [CODE_W-1:0] NO_CODE     = 6'd51;

    // special bytes
    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] LF_BYTE  = 8'h0A;
    localparam logic [7:0] CH_PCT   = "%";
    localparam logic [7:0] CH_AMP   = "&";
    localparam logic [7:0] CH_LB    = "b";
    localparam logic [7:0] CH_T     = "T";
    localparam logic [7:0] CH_W     = "W";
    localparam logic [7:0] CH_V     = "V";

    // tail that marks a known pjl line after the percent head
    localparam logic [7:0] PJL_TAIL [0:6] = '{"-", "1", "2", "3", "4", "5", "X"};

    // head, group, terminator triples in table order
    localparam logic [23:0] CMD_TABLE [0:TABLE_SIZE-1] = '{
        "&bW", "&bE", "&bT",
        "&lX", "&lS", "&lU", "&lZ", "&lT",
        "&lG", "&lA", "&lP", "&lH", "&lO",
        "&lF", "&lL", "&lM", "&lE",
        "&aG", "&aP", "&aL", "&aM", "&aE",
        "&uD", "&kG", "&pX",
        "*oW", "*oM", "*oD",
        "*tR", "*cF", "*pX", "*pY", "*gW",
        "*rA", "*rB", "*rC", "*rS", "*rU",
        "*rQ", "*vS",
        "*bW", "*bV", "*bM", "*bS", "*bY"
    };

    typedef struct packed {
        logic [7:0] head;
        logic [7:0] group;
        logic [7:0] term;
    } t_lookup_req;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_lookup_rsp;

    // code of a one-byte command head, zero when the head is not one
    function automatic logic [2:0] single_code(input logic [7:0] b);
        logic [2:0] c;
        c = 3'd0;
        case (b)
            "z":     c = 3'd1;
            "Y":     c = 3'd2;
            "Z":     c = 3'd3;
            "E":     c = 3'd4;
            "9":     c = 3'd5;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/pesp_in_if.sv -----
// ----------------------------------------------------------------------------
// pesp_in_if
// byte channel into the parser
// ----------------------------------------------------------------------------
interface pesp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/core/pesp_out_if.sv -----
// ----------------------------------------------------------------------------
// pesp_out_if
// result channel out of the parser
// ----------------------------------------------------------------------------
interface pesp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  head_byte;
    logic [7:0]  group_byte;
    logic [7:0]  term_byte;
    logic [5:0]  command_code;
    logic [23:0] param_value;
    logic [23:0] payload_len;
    logic [7:0]  payload_byte;
    logic        last_of_run;

    modport source (
        output valid, output kind, output head_byte, output group_byte,
        output term_byte, output command_code, output param_value,
        output payload_len, output payload_byte, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input kind, input head_byte, input group_byte,
        input term_byte, input command_code, input param_value,
        input payload_len, input payload_byte, input last_of_run,
        output ready
    );
endinterface

// ----- rtl/core/pesp_cmd_lookup.sv -----
// ----------------------------------------------------------------------------
// pesp_cmd_lookup
// matches a head, group, terminator triple against the command table
// ----------------------------------------------------------------------------
module pesp_cmd_lookup (
    input  pesp_pkg::t_lookup_req i_req,
    output pesp_pkg::t_lookup_rsp o_rsp
);

    always_comb begin
        o_rsp.hit  = 1'b0;
        o_rsp.code = pesp_pkg::NO_CODE;
        // table entries are distinct, at most one compare fires
        for (int i = 0; i < pesp_pkg::TABLE_SIZE; i++) begin
            if (pesp_pkg::CMD_TABLE[i] == {i_req.head, i_req.group, i_req.term}) begin
                o_rsp.hit  = 1'b1;
                o_rsp.code = pesp_pkg::TABLE_BASE + 6'(i);
            end
        end
    end

endmodule

// ----- rtl/core/printer_escape_sequence_parser.sv -----
// ----------------------------------------------------------------------------
// printer_escape_sequence_parser
// byte-wise parser of printer escape sequences with payload pass-through
// ----------------------------------------------------------------------------
// usage
// - i_in carries one command stream byte per transaction; o_out carries one
//   result per transaction: a recognised command, a payload byte or an
//   unknown command error
// - a byte is taken into an input register, decoded against the parse state and
//   the command table, and its result (if any) lands in the output register
// - one byte per cycle sustained unless o_out stalls; the input register and the
//   output register advance together, so the input keeps flowing while a result
//   waits as long as the output register frees up in the same cycle
// - when the receiver stalls, the result holds in the output register, one
//   more byte parks in the input register and then i_in.ready drops
// - bytes that cause no result simply disappear, no transaction on o_out
// - after an unknown command the parser keeps taking bytes but drops them
//   until reset
// - reset (synchronous, active low) returns to skipping bytes until escape,
//   with both registers empty
// ----------------------------------------------------------------------------
module printer_escape_sequence_parser #(
    parameter int VALUE_BITS = pesp_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pesp_in_if.sink           i_in,
    pesp_out_if.source        o_out
);

    localparam int OUT_W = pesp_pkg::OUT_VAL_W;
    localparam int EXT_W = VALUE_BITS + 4;

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_HEAD,
        MODE_PJL,
        MODE_GROUP,
        MODE_PARAM,
        MODE_PAYLOAD
    } t_mode;

    // parse state
    t_mode                 r_mode,  n_mode;
    logic [7:0]            r_head,  n_head;
    logic [7:0]            r_group, n_group;
    logic [VALUE_BITS-1:0] r_digit, n_digit;
    logic                  r_open,  n_open;
    logic [2:0]            r_pos,   n_pos;
    logic                  r_pjl_ok, n_pjl_ok;
    logic [VALUE_BITS-1:0] r_left,  n_left;
    logic                  r_comb,  n_comb;
    logic                  r_halt,  n_halt;

    // input register
    logic                  r_in_vld;
    logic [7:0]            r_in_byte;

    // output register
    logic                  r_out_vld,  n_out_vld;
    logic [1:0]            r_kind,     n_kind;
    logic [7:0]            r_o_head,   n_o_head;
    logic [7:0]            r_o_group,  n_o_group;
    logic [7:0]            r_o_term,   n_o_term;
    logic [5:0]            r_o_code,   n_o_code;
    logic [OUT_W-1:0]      r_o_val,    n_o_val;
    logic [OUT_W-1:0]      r_o_len,    n_o_len;
    logic [7:0]            r_o_pbyte,  n_o_pbyte;
    logic                  r_o_last,   n_o_last;

    logic                  w_adv;
    logic                  w_step;
    logic                  w_upper;
    logic                  w_lower;
    logic                  w_digit;
    logic [7:0]            w_term;
    logic [2:0]            w_single;
    logic [EXT_W-1:0]      w_acc;
    logic [VALUE_BITS-1:0] w_sat;
    logic [VALUE_BITS-1:0] w_len;
    logic [VALUE_BITS-1:0] w_dec;
    logic                  w_comb;
    pesp_pkg::t_lookup_req w_req;
    pesp_pkg::t_lookup_rsp w_rsp;

    // both registers move when the output register is free or being drained
    assign w_adv       = !r_out_vld || o_out.ready;
    assign w_step      = r_in_vld && w_adv && !r_halt;
    assign i_in.ready  = !r_in_vld || w_adv;

    // byte classes
    assign w_upper  = (r_in_byte >= "A") && (r_in_byte <= "Z");
    assign w_lower  = (r_in_byte >= "a") && (r_in_byte <= "z");
    assign w_digit  = (r_in_byte >= "0") && (r_in_byte <= "9");
    assign w_term   = w_upper ? r_in_byte : r_in_byte - 8'd32;
    assign w_single = pesp_pkg::single_code(r_in_byte);

    // value times ten plus digit, saturated to the value width
    assign w_acc = (EXT_W'(r_digit) << 3) + (EXT_W'(r_digit) << 1)
                 + EXT_W'(r_in_byte[3:0]);
    assign w_sat = (w_acc[EXT_W-1:VALUE_BITS] != '0) ? {VALUE_BITS{1'b1}}
                                                     : w_acc[VALUE_BITS-1:0];

    assign w_req.head  = r_head;
    assign w_req.group = r_group;
    assign w_req.term  = w_term;

    pesp_cmd_lookup u_lookup (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // lower-case terminator keeps head and group, except for the &b...t case
    assign w_comb = w_lower && !((r_head == pesp_pkg::CH_AMP) && (r_group == pesp_pkg::CH_LB)
                                 && (w_term == pesp_pkg::CH_T));
    assign w_len  = ((w_term == pesp_pkg::CH_W) || (w_term == pesp_pkg::CH_V)) ? r_digit : '0;
    assign w_dec  = (r_left != '0) ? r_left - VALUE_BITS'(1) : '0;

    always_comb begin
        n_mode    = r_mode;
        n_head    = r_head;
        n_group   = r_group;
        n_digit   = r_digit;
        n_open    = r_open;
        n_pos     = r_pos;
        n_pjl_ok  = r_pjl_ok;
        n_left    = r_left;
        n_comb    = r_comb;
        n_halt    = r_halt;

        n_out_vld = 1'b0;
        n_kind    = pesp_pkg::KIND_CMD;
        n_o_head  = '0;
        n_o_group = '0;
        n_o_term  = '0;
        n_o_code  = pesp_pkg::NO_CODE;
        n_o_val   = '0;
        n_o_len   = '0;
        n_o_pbyte = '0;
        n_o_last  = 1'b0;

        if (w_step) begin
            unique case (r_mode)
                MODE_HEAD: begin
                    n_head  = r_in_byte;
                    n_group = '0;
                    n_comb  = 1'b0;
                    if (r_in_byte == pesp_pkg::CH_PCT) begin
                        n_mode   = MODE_PJL;
                        n_pos    = '0;
                        n_pjl_ok = 1'b1;
                    end else if (w_single != 3'd0) begin
                        // one-byte command reports at once
                        n_mode    = MODE_SKIP;
                        n_out_vld = 1'b1;
                        n_o_head  = r_in_byte;
                        n_o_code  = 6'(w_single);
                        n_o_last  = 1'b1;
                    end else begin
                        n_mode = MODE_GROUP;
                    end
                end
                MODE_PJL: begin
                    if (r_in_byte == pesp_pkg::LF_BYTE) begin
                        if (r_pjl_ok && (r_pos == 3'd7)) begin
                            n_mode    = MODE_SKIP;
                            n_out_vld = 1'b1;
                            n_o_head  = pesp_pkg::CH_PCT;
                            n_o_term  = pesp_pkg::LF_BYTE;
                            n_o_code  = pesp_pkg::CODE_PJL;
                            n_o_last  = 1'b1;
                        end else begin
                            // unmatched line goes on as a group sequence
                            n_mode = MODE_GROUP;
                        end
                    end else if (r_pos != 3'd7) begin
                        if (pesp_pkg::PJL_TAIL[r_pos] != r_in_byte) begin
                            n_pjl_ok = 1'b0;
                        end
                        n_pos = r_pos + 3'd1;
                    end
                end
                MODE_GROUP: begin
                    n_group = r_in_byte;
                    n_mode  = MODE_PARAM;
                    n_digit = '0;
                    n_open  = 1'b1;
                end
                MODE_PARAM: begin
                    if (!w_upper && !w_lower) begin
                        if (r_open && w_digit) begin
                            n_digit = w_sat;
                        end else begin
                            n_open = 1'b0;
                        end
                    end else if (!w_rsp.hit) begin
                        // unknown command: report and halt until reset
                        n_halt    = 1'b1;
                        n_mode    = MODE_SKIP;
                        n_out_vld = 1'b1;
                        n_kind    = pesp_pkg::KIND_ERROR;
                        n_o_head  = r_head;
                        n_o_group = r_group;
                        n_o_term  = w_term;
                        n_o_val   = OUT_W'(r_digit);
                        n_o_last  = 1'b1;
                    end else begin
                        n_comb    = w_comb;
                        n_out_vld = 1'b1;
                        n_o_head  = r_head;
                        n_o_group = r_group;
                        n_o_term  = w_term;
                        n_o_code  = w_rsp.code;
                        n_o_val   = OUT_W'(r_digit);
                        n_o_len   = OUT_W'(w_len);
                        n_o_last  = (w_len == '0);
                        if (w_len != '0) begin
                            n_left = w_len;
                            n_mode = MODE_PAYLOAD;
                        end else if (w_comb) begin
                            n_mode  = MODE_PARAM;
                            n_digit = '0;
                            n_open  = 1'b1;
                        end else begin
                            n_mode = MODE_SKIP;
                        end
                    end
                end
                MODE_PAYLOAD: begin
                    n_left    = w_dec;
                    n_out_vld = 1'b1;
                    n_kind    = pesp_pkg::KIND_PAYLOAD;
                    n_o_pbyte = r_in_byte;
                    n_o_last  = (w_dec == '0);
                    if (w_dec == '0) begin
                        if (r_comb) begin
                            n_mode  = MODE_PARAM;
                            n_digit = '0;
                            n_open  = 1'b1;
                        end else begin
                            n_mode = MODE_SKIP;
                        end
                    end
                end
                default: begin
                    n_mode = (r_in_byte == pesp_pkg::ESC_BYTE) ? MODE_HEAD : MODE_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_SKIP;
            r_head    <= '0;
            r_group   <= '0;
            r_digit   <= '0;
            r_open    <= 1'b1;
            r_pos     <= '0;
            r_pjl_ok  <= 1'b1;
            r_left    <= '0;
            r_comb    <= 1'b0;
            r_halt    <= 1'b0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_head    <= n_head;
            r_group   <= n_group;
            r_digit   <= n_digit;
            r_open    <= n_open;
            r_pos     <= n_pos;
            r_pjl_ok  <= n_pjl_ok;
            r_left    <= n_left;
            r_comb    <= n_comb;
            r_halt    <= n_halt;
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= n_out_vld;
            end
        end
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
        if (w_adv) begin
            r_kind    <= n_kind;
            r_o_head  <= n_o_head;
            r_o_group <= n_o_group;
            r_o_term  <= n_o_term;
            r_o_code  <= n_o_code;
            r_o_val   <= n_o_val;
            r_o_len   <= n_o_len;
            r_o_pbyte <= n_o_pbyte;
            r_o_last  <= n_o_last;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.kind         = r_kind;
    assign o_out.head_byte    = r_o_head;
    assign o_out.group_byte   = r_o_group;
    assign o_out.term_byte    = r_o_term;
    assign o_out.command_code = r_o_code;
    assign o_out.param_value  = r_o_val;
    assign o_out.payload_len  = r_o_len;
    assign o_out.payload_byte = r_o_pbyte;
    assign o_out.last_of_run  = r_o_last;

    // once halted, only reset leaves the halt
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt released without reset");

    // an error result always comes with the halt already taken
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_kind == pesp_pkg::KIND_ERROR)) |-> r_halt)
        else $error("error reported without halting");

    // payload mode is only held while bytes remain
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PAYLOAD) |-> (r_left != '0))
        else $error("payload mode with zero bytes left");

    // a payload result is final exactly when its countdown ended
    a_payload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_step && (r_mode == MODE_PAYLOAD)) |=> (r_o_last == (r_mode != MODE_PAYLOAD)))
        else $error("payload end flag out of step with mode");

endmodule
